>>> design/gbn_pkg.sv
// shared types and constants for the go-back-n sender window
`timescale 1ns / 1ps
package gbn_pkg;

  // field widths
  localparam int SEQ_W  = 31;
  localparam int ACT_W  = 2;
  localparam int OUTS_W = 7;

  // action codes
  localparam logic [ACT_W-1:0] ACT_START   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ACK     = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TIMEOUT = 2'd2;

  // configuration register indexes
  localparam logic REG_TOTAL_REQUESTS = 1'b0;

  // reset value of the total_requests register
  localparam logic [SEQ_W-1:0] TOTAL_RESET = 31'd1000000;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;  // take the accepted item and plan its run
    logic emit;  // write one result into the output register
  } gbn_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic last_item;  // the next result emitted ends the run
  } gbn_status_t;

endpackage

>>> design/gbn_ctrl.sv
// controller state machine: takes items and paces the result run
`timescale 1ns / 1ps
module gbn_ctrl
  import gbn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  gbn_status_t status,
  output gbn_cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state;
  logic state_next;

  // item transfer only while idle
  assign in_stall = (state != ST_IDLE);
  assign cmd.load = in_valid && (state == ST_IDLE);
  assign cmd.emit = (state == ST_EMIT) && status.out_free;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.load) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd.emit && status.last_item) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

endmodule

>>> design/gbn_datapath.sv
// datapath: window counters, run planning and the output register
`timescale 1ns / 1ps
module gbn_datapath
  import gbn_pkg::*;
#(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  gbn_cmd_t          cmd,
  output gbn_status_t       status,
  input  logic [SEQ_W-1:0]  total_requests,
  input  logic [ACT_W-1:0]  action,
  input  logic [SEQ_W-1:0]  ack_seq,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              send_valid,
  output logic [SEQ_W-1:0]  send_seq,
  output logic              is_retransmit,
  output logic              last_of_run,
  output logic              all_done,
  output logic [OUTS_W-1:0] outstanding
);

  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam logic [SEQ_W-1:0] WIN_SEQ = SEQ_W'(WINDOW_DEPTH);
  localparam logic [CNT_W-1:0] WIN_CNT = CNT_W'(WINDOW_DEPTH);

  // window state
  logic             window_base;
  logic [SEQ_W-1:0] base;
  logic [SEQ_W-1:0] next_seq;
  logic             started;

  // run in progress
  logic [CNT_W-1:0] remaining;
  logic [SEQ_W-1:0] cursor;
  logic             retx;
  logic             done_run;
  logic [OUTS_W-1:0] outs_run;

  // planned values for the accepted item
  logic [SEQ_W-1:0] base_next;
  logic [SEQ_W-1:0] next_seq_next;
  logic             started_next;
  logic [CNT_W-1:0] remaining_next;
  logic [SEQ_W-1:0] cursor_next;
  logic             retx_next;
  logic             done_now;
  logic [SEQ_W-1:0] in_flight;
  logic [SEQ_W-1:0] outs_diff;

  assign window_base = 1'b0;  // base of a fresh window after a start
  assign done_now  = started && (base >= total_requests);
  assign in_flight = next_seq - base;

  // plan the run and the window state after this item
  always_comb begin
    base_next      = base;
    next_seq_next  = next_seq;
    started_next   = started;
    remaining_next = '0;
    cursor_next    = '0;
    retx_next      = 1'b0;
    case (action)
      ACT_START: begin
        base_next    = '0;
        started_next = 1'b1;
        if (total_requests < WIN_SEQ) begin
          remaining_next = total_requests[CNT_W-1:0];
          next_seq_next  = total_requests;
        end else begin
          remaining_next = WIN_CNT;
          next_seq_next  = WIN_SEQ;
        end
        cursor_next = {SEQ_W{window_base}};
      end
      ACT_ACK: begin
        if (started && !done_now && (ack_seq == base)) begin
          base_next = base + 1'b1;
          if (next_seq < total_requests) begin
            remaining_next = CNT_W'(1);
            cursor_next    = next_seq;
            next_seq_next  = next_seq + 1'b1;
          end
        end
      end
      ACT_TIMEOUT: begin
        if (started && !done_now) begin
          retx_next   = 1'b1;
          cursor_next = base;
          if (in_flight > WIN_SEQ) remaining_next = WIN_CNT;
          else                     remaining_next = in_flight[CNT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign outs_diff = next_seq_next - base_next;

  // window state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base     <= '0;
      next_seq <= '0;
      started  <= 1'b0;
    end else if (cmd.load) begin
      base     <= base_next;
      next_seq <= next_seq_next;
      started  <= started_next;
    end
  end

  // run registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      remaining <= remaining_next;
      cursor    <= cursor_next;
      retx      <= retx_next;
      done_run  <= started_next && (base_next >= total_requests);
      outs_run  <= outs_diff[OUTS_W-1:0];
    end else if (cmd.emit && (remaining != '0)) begin
      remaining <= remaining - 1'b1;
      cursor    <= cursor + 1'b1;
    end
  end

  assign status.out_free  = !out_valid || !out_stall;
  assign status.last_item = (remaining <= CNT_W'(1));

  // output valid
  always_ff @(posedge clk) begin
    if (rst)                       out_valid <= 1'b0;
    else if (cmd.emit)             out_valid <= 1'b1;
    else if (out_valid && !out_stall) out_valid <= 1'b0;
  end

  // output payload, one result per transfer
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      send_valid    <= (remaining != '0);
      send_seq      <= (remaining != '0) ? cursor : '0;
      is_retransmit <= retx && (remaining != '0);
      last_of_run   <= status.last_item;
      all_done      <= done_run;
      outstanding   <= outs_run;
    end
  end

endmodule

>>> design/go_back_n_sender_window_unit.sv
// Go-back-N sender window: top level with the configuration port.
// Each accepted item is taken while the controller is idle and then produces its
// results one per cycle from a single output register, except while the output
// side stalls: a start or timeout item sends n packets (n at most WINDOW_DEPTH),
// an acknowledgment sends at most one, and an item that sends nothing still puts
// out one result with send_valid low. The next item is taken once the last result
// of the run is in the output register. Acks count only when they match the window
// base exactly. total_requests is written over the APB port at byte address 0
// and should only be changed while no run is in progress.
`timescale 1ns / 1ps
module go_back_n_sender_window_unit
  import gbn_pkg::*;
#(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // input items
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ACT_W-1:0]  action,
  input  logic [SEQ_W-1:0]  ack_seq,
  // result items
  output logic              out_valid,
  input  logic              out_stall,
  output logic              send_valid,
  output logic [SEQ_W-1:0]  send_seq,
  output logic              is_retransmit,
  output logic              last_of_run,
  output logic              all_done,
  output logic [OUTS_W-1:0] outstanding
);

  logic [SEQ_W-1:0] total_requests;
  gbn_cmd_t         cmd;
  gbn_status_t      status;

  assign pready = 1'b1;

  // total_requests register
  always_ff @(posedge clk) begin
    if (rst) begin
      total_requests <= TOTAL_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_TOTAL_REQUESTS)) begin
      total_requests <= pwdata[SEQ_W-1:0];
    end
  end

  // register read back
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TOTAL_REQUESTS) prdata = {1'b0, total_requests};
  end

  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  gbn_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .total_requests (total_requests),
    .action         (action),
    .ack_seq        (ack_seq),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .send_valid     (send_valid),
    .send_seq       (send_seq),
    .is_retransmit  (is_retransmit),
    .last_of_run    (last_of_run),
    .all_done       (all_done),
    .outstanding    (outstanding)
  );

endmodule
